@@ rtl/power_button_long_press_controller_core_macros.svh @@
// ----------------------------------------------------------------------------
// Power button long-press controller: assertion macros
// Shared concurrent assertion forms, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef POWER_BUTTON_LONG_PRESS_CONTROLLER_CORE_MACROS_SVH
`define POWER_BUTTON_LONG_PRESS_CONTROLLER_CORE_MACROS_SVH

// Checked only outside reset.
`define PBLP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PBLP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/pblp_pkg.sv @@
// ----------------------------------------------------------------------------
// pblp_pkg
// Types, register indexes and reset values for the long-press controller.
// ----------------------------------------------------------------------------
package pblp_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_TIME     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_UNTIL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_STABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CUT_EARLIEST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CUT_DEADLINE = 3'd5;

    // Reset values
    localparam logic [31:0] RST_ARM_TIME     = 32'd3000;
    localparam logic [31:0] RST_GUARD_UNTIL  = 32'd0;
    localparam logic [15:0] RST_HOLD         = 16'd500;
    localparam logic [15:0] RST_IDLE_STABLE  = 16'd1200;
    localparam logic [15:0] RST_CUT_EARLIEST = 16'd100;
    localparam logic [15:0] RST_CUT_DEADLINE = 16'd320;

    typedef enum logic [1:0] {
        BLK_NONE  = 2'd0,
        BLK_USB   = 2'd1,
        BLK_GUARD = 2'd2
    } t_block_reason;

    typedef struct packed {
        logic [31:0] arm_time_ms;
        logic [31:0] guard_until_ms;
        logic [15:0] hold_ms;
        logic [15:0] idle_stable_ms;
        logic [15:0] cut_earliest_ms;
        logic [15:0] cut_deadline_ms;
    } t_cfg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        power_pressed;
        logic        boot_pressed;
        logic        usb_present;
        logic        audio_idle;
        logic        scanning;
    } t_poll;

    typedef struct packed {
        logic          armed;
        logic          off_request;
        logic          cut_power;
        logic          display_lock;
        t_block_reason block_reason;
    } t_result;

endpackage

@@ rtl/pblp_cfg.sv @@
// ----------------------------------------------------------------------------
// pblp_cfg
// Configuration register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module pblp_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pblp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pblp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output pblp_pkg::t_cfg                     o_cfg
);

    pblp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arm_time_ms     <= pblp_pkg::RST_ARM_TIME;
            r_cfg.guard_until_ms  <= pblp_pkg::RST_GUARD_UNTIL;
            r_cfg.hold_ms         <= pblp_pkg::RST_HOLD;
            r_cfg.idle_stable_ms  <= pblp_pkg::RST_IDLE_STABLE;
            r_cfg.cut_earliest_ms <= pblp_pkg::RST_CUT_EARLIEST;
            r_cfg.cut_deadline_ms <= pblp_pkg::RST_CUT_DEADLINE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pblp_pkg::CFG_ARM_TIME:     r_cfg.arm_time_ms     <= i_cfg_wdata;
                pblp_pkg::CFG_GUARD_UNTIL:  r_cfg.guard_until_ms  <= i_cfg_wdata;
                pblp_pkg::CFG_HOLD:         r_cfg.hold_ms         <= i_cfg_wdata[15:0];
                pblp_pkg::CFG_IDLE_STABLE:  r_cfg.idle_stable_ms  <= i_cfg_wdata[15:0];
                pblp_pkg::CFG_CUT_EARLIEST: r_cfg.cut_earliest_ms <= i_cfg_wdata[15:0];
                pblp_pkg::CFG_CUT_DEADLINE: r_cfg.cut_deadline_ms <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/pblp_step.sv @@
// ----------------------------------------------------------------------------
// pblp_step
// Controller state and the single-pass update for one poll.
// ----------------------------------------------------------------------------
module pblp_step #(
    parameter int TIME_BITS = pblp_pkg::TIME_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,      // commit the update for i_poll
    input  pblp_pkg::t_poll     i_poll,
    input  pblp_pkg::t_cfg      i_cfg,
    output pblp_pkg::t_result   o_result
);

    typedef logic [TIME_BITS-1:0] t_time;

    // flags
    logic r_armed, r_seen_rel, r_idle_st, r_hold_act, r_cut_pend, r_boot_held;
    logic r_lock, r_halted;
    logic n_armed, n_seen_rel, n_idle_st, n_hold_act, n_cut_pend, n_boot_held;
    logic n_lock, n_halted;
    // timestamps
    t_time r_idle_since, r_hold_since, r_cut_early_at, r_cut_dead_at;
    t_time n_idle_since, n_hold_since, n_cut_early_at, n_cut_dead_at;

    t_time now_t, arm_t, guard_t;
    logic  req;
    pblp_pkg::t_block_reason reason;

    assign now_t   = TIME_BITS'(i_poll.now_ms);
    assign arm_t   = TIME_BITS'(i_cfg.arm_time_ms);
    assign guard_t = TIME_BITS'(i_cfg.guard_until_ms);

    always_comb begin
        t_time idle_el;
        t_time hold_el;
        n_armed        = r_armed;
        n_seen_rel     = r_seen_rel;
        n_idle_st      = r_idle_st;
        n_hold_act     = r_hold_act;
        n_cut_pend     = r_cut_pend;
        n_boot_held    = r_boot_held;
        n_lock         = r_lock;
        n_halted       = r_halted;
        n_idle_since   = r_idle_since;
        n_hold_since   = r_hold_since;
        n_cut_early_at = r_cut_early_at;
        n_cut_dead_at  = r_cut_dead_at;
        req            = 1'b0;
        reason         = pblp_pkg::BLK_NONE;
        idle_el        = now_t - r_idle_since;
        hold_el        = now_t - r_hold_since;

        if (!r_halted) begin
            if (!r_armed && i_poll.scanning && now_t >= arm_t) begin
                n_armed      = 1'b1;
                n_seen_rel   = 1'b0;
                n_idle_st    = 1'b0;
                n_idle_since = now_t;
                idle_el      = '0;
            end
            if (n_armed) begin
                if (!i_poll.power_pressed) begin
                    n_seen_rel = 1'b1;
                    if (!n_idle_st && idle_el >= TIME_BITS'(i_cfg.idle_stable_ms))
                        n_idle_st = 1'b1;
                end else begin
                    n_idle_since = now_t;
                end

                if (i_poll.power_pressed && n_seen_rel && n_idle_st && !r_cut_pend) begin
                    if (!r_hold_act) begin
                        n_hold_act   = 1'b1;
                        n_hold_since = now_t;
                    end else if (hold_el >= TIME_BITS'(i_cfg.hold_ms)) begin
                        priority if (i_poll.usb_present) begin
                            reason = pblp_pkg::BLK_USB;
                        end else if (guard_t != '0 && now_t < guard_t) begin
                            reason = pblp_pkg::BLK_GUARD;
                        end else begin
                            req            = 1'b1;
                            n_cut_pend     = 1'b1;
                            n_cut_early_at = now_t + TIME_BITS'(i_cfg.cut_earliest_ms);
                            n_cut_dead_at  = now_t + TIME_BITS'(i_cfg.cut_deadline_ms);
                        end
                        n_hold_since = now_t;
                    end
                end else begin
                    n_hold_act = 1'b0;
                end

                if (n_cut_pend && (now_t >= n_cut_dead_at ||
                                   (i_poll.audio_idle && now_t >= n_cut_early_at)))
                    n_halted = 1'b1;

                if (!n_halted) begin
                    if (i_poll.boot_pressed && !r_boot_held) begin
                        n_boot_held = 1'b1;
                        n_lock      = !r_lock;
                    end else if (!i_poll.boot_pressed && r_boot_held) begin
                        n_boot_held = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_seen_rel  <= 1'b0;
            r_idle_st   <= 1'b0;
            r_hold_act  <= 1'b0;
            r_cut_pend  <= 1'b0;
            r_boot_held <= 1'b0;
            r_lock      <= 1'b0;
            r_halted    <= 1'b0;
        end else if (i_adv) begin
            r_armed     <= n_armed;
            r_seen_rel  <= n_seen_rel;
            r_idle_st   <= n_idle_st;
            r_hold_act  <= n_hold_act;
            r_cut_pend  <= n_cut_pend;
            r_boot_held <= n_boot_held;
            r_lock      <= n_lock;
            r_halted    <= n_halted;
        end
    end

    // timestamps are only read behind their flags
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_idle_since   <= n_idle_since;
            r_hold_since   <= n_hold_since;
            r_cut_early_at <= n_cut_early_at;
            r_cut_dead_at  <= n_cut_dead_at;
        end
    end

    assign o_result.armed        = n_armed;
    assign o_result.off_request  = req;
    assign o_result.cut_power    = n_halted;
    assign o_result.display_lock = n_lock;
    assign o_result.block_reason = reason;

endmodule

@@ rtl/power_button_long_press_controller_core.sv @@
// ----------------------------------------------------------------------------
// power_button_long_press_controller_core
// Long-press power-off controller with arming, guard and timed power cut.
// ----------------------------------------------------------------------------
// Each input transaction is one poll; each poll yields exactly one result
// transaction. Polls pass through an input register, one pass of compare and
// update logic against the controller state, and a result register. A taken
// poll is loaded into the input register, and its result is loaded into the
// result register once that slot is free or being read. A new poll can be
// taken every cycle while results are taken. The result register lets the next
// poll enter while a finished result waits on i_out_ready; the input side stalls
// only when both registers are full and the result is not taken. Configuration
// writes land at once and should be made while no poll is in flight. All
// timestamps are TIME_BITS wide; elapsed times wrap.
// ----------------------------------------------------------------------------
module power_button_long_press_controller_core #(
    parameter int TIME_BITS = pblp_pkg::TIME_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [pblp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pblp_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // poll channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [31:0]                      i_now_ms,
    input  logic                             i_power_pressed,
    input  logic                             i_boot_pressed,
    input  logic                             i_usb_present,
    input  logic                             i_audio_idle,
    input  logic                             i_scanning,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_armed,
    output logic                             o_off_request,
    output logic                             o_cut_power,
    output logic                             o_display_lock,
    output logic [1:0]                       o_block_reason
);

    pblp_pkg::t_cfg    cfg;
    pblp_pkg::t_poll   r_poll;
    pblp_pkg::t_result r_res;
    pblp_pkg::t_result step_res;
    logic              r_poll_vld, r_res_vld;
    logic              adv;

    pblp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // held poll moves into the result register when that slot is free or its result is being taken
    assign adv        = r_poll_vld && (!r_res_vld || i_out_ready);
    assign o_in_ready = !r_poll_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_vld <= 1'b0;
            r_res_vld  <= 1'b0;
        end else begin
            if (o_in_ready)
                r_poll_vld <= i_in_valid;
            if (adv)
                r_res_vld <= 1'b1;
            else if (i_out_ready)
                r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_poll.now_ms        <= i_now_ms;
            r_poll.power_pressed <= i_power_pressed;
            r_poll.boot_pressed  <= i_boot_pressed;
            r_poll.usb_present   <= i_usb_present;
            r_poll.audio_idle    <= i_audio_idle;
            r_poll.scanning      <= i_scanning;
        end
        if (adv)
            r_res <= step_res;
    end

    pblp_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_poll   (r_poll),
        .i_cfg    (cfg),
        .o_result (step_res)
    );

    assign o_out_valid    = r_res_vld;
    assign o_armed        = r_res.armed;
    assign o_off_request  = r_res.off_request;
    assign o_cut_power    = r_res.cut_power;
    assign o_display_lock = r_res.display_lock;
    assign o_block_reason = r_res.block_reason;

endmodule

@@ rtl/pblp_checker.sv @@
// ----------------------------------------------------------------------------
// pblp_checker
// Port-level checks on the long-press controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "power_button_long_press_controller_core_macros.svh"

module pblp_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       o_out_valid,
    input  logic       i_out_ready,
    input  logic       o_armed,
    input  logic       o_off_request,
    input  logic       o_cut_power,
    input  logic       o_display_lock,
    input  logic [1:0] o_block_reason
);

    logic [5:0] res_bits;
    logic       stalled;
    logic       blocked;
    logic       blk_ok;
    logic       acting;

    assign res_bits = {o_armed, o_off_request, o_cut_power, o_display_lock, o_block_reason};
    assign stalled  = o_out_valid && !i_out_ready;
    assign blocked  = o_block_reason != pblp_pkg::BLK_NONE;
    assign blk_ok   = o_armed && !o_off_request && !o_cut_power &&
                      (o_block_reason == pblp_pkg::BLK_USB ||
                       o_block_reason == pblp_pkg::BLK_GUARD);
    assign acting   = o_off_request || o_cut_power;

    // stalled result transaction holds
    `PBLP_ASSERT(a_out_hold, stalled |=> o_out_valid && $stable(res_bits), "result changed while stalled")

    // no result straight out of reset
    `PBLP_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // a blocked hold never requests or cuts
    `PBLP_ASSERT(a_block_excl, o_out_valid && blocked |-> blk_ok, "blocked hold with request or cut")

    // requests and cuts only once armed
    `PBLP_ASSERT(a_armed_first, o_out_valid && acting |-> o_armed, "request or cut while disarmed")

endmodule

bind power_button_long_press_controller_core pblp_checker u_pblp_checker (.*);
